// ===== hdl/stpe_pkg.sv =====
// ----------------------------------------------------------------------------
// stpe_pkg
// shared constants, types and the rounding function of the saddle torus
// point evaluator
// ----------------------------------------------------------------------------
package stpe_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int PHASE_BITS     = 16;
    localparam int PHASE_W        = 16;
    localparam int COORD_W        = 19;
    localparam int TURN_W         = 32;
    localparam int TRIG_W         = 32;
    localparam int CORE_W         = 34;
    localparam int ANGLE_W        = 33;
    localparam int ATAN_W         = 30;
    localparam int ROOT_W         = 32;
    localparam int WIDE_W         = 64;

    localparam int CORDIC_STEPS   = 24;
    localparam int ROOT_STEPS     = 32;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam int CORDIC_LAT     = CORDIC_STEPS + 2;
    localparam int SIGN_DELAY     = ROOT_STEPS;
    localparam int XY_DELAY       = ROOT_STEPS + 1;
    localparam int OUT_LAT        = CORDIC_LAT + 2 + ROOT_STEPS + 2;

    localparam logic signed [CORE_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORE_W-1:0] TWO_Q30     = 34'sd2147483648;
    localparam logic [TURN_W-1:0]        THIRD_TURN  = 32'h5555_5555;

    localparam logic [ATAN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004757,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef struct packed {
        logic              valid;
        logic [TURN_W-1:0] pu;
        logic [TURN_W-1:0] pv;
    } t_job;

    function automatic logic [COORD_W-1:0] finish_q60(input logic signed [WIDE_W-1:0] q);
        logic signed [WIDE_W:0] qe;
        logic signed [WIDE_W:0] r;
        logic signed [WIDE_W:0] lim;
        qe  = (WIDE_W+1)'(q);
        lim = 65'sd3 <<< FRAC_BITS;
        r   = (qe + (65'sd1 <<< (60 - FRAC_BITS - 1))) >>> (60 - FRAC_BITS);
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r[COORD_W-1:0];
    endfunction

endpackage

// ===== hdl/saddle_torus_point_eval.sv =====
// ----------------------------------------------------------------------------
// saddle_torus_point_eval
// one point of the saddle torus surface for each pair of phases
// ----------------------------------------------------------------------------
// A start transaction is taken whenever busy is low, one per clock. Each one
// gives exactly one strobe on o_valid, in the order taken, carrying x, y and
// z in signed fixed point with 16 fraction bits. The path runs through the
// input queue, the cordic lanes, two product and magnitude stages, the
// 32-stage square root pipeline and two output stages; the evaluator never
// stalls, so the 4-entry input queue drains every cycle and busy stays low in
// normal use. Results must be taken in the strobe cycle.
module saddle_torus_point_eval (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic [stpe_pkg::PHASE_W-1:0]          i_u_phase,
    input  logic [stpe_pkg::PHASE_W-1:0]          i_v_phase,
    output logic                                  busy,
    output logic                                  o_valid,
    output logic signed [stpe_pkg::COORD_W-1:0]   o_x_pos,
    output logic signed [stpe_pkg::COORD_W-1:0]   o_y_pos,
    output logic signed [stpe_pkg::COORD_W-1:0]   o_z_pos
);
    import stpe_pkg::*;

    t_job job;

    stpe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_u_phase (i_u_phase),
        .i_v_phase (i_v_phase),
        .busy      (busy),
        .o_job     (job)
    );

    stpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .o_valid (o_valid),
        .o_x_pos (o_x_pos),
        .o_y_pos (o_y_pos),
        .o_z_pos (o_z_pos)
    );

endmodule

// ===== hdl/stpe_front.sv =====
// ----------------------------------------------------------------------------
// stpe_front
// takes start transactions, widens the phases and queues them for the back end
// ----------------------------------------------------------------------------
module stpe_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [stpe_pkg::PHASE_W-1:0]   i_u_phase,
    input  logic [stpe_pkg::PHASE_W-1:0]   i_v_phase,
    output logic                           busy,
    output stpe_pkg::t_job                 o_job
);
    import stpe_pkg::*;

    logic [PHASE_W-1:0]        r_q_u [QUEUE_DEPTH];
    logic [PHASE_W-1:0]        r_q_v [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [COUNT_BITS-1:0]     r_count, n_count;
    logic                      push;
    logic                      pop;

    assign busy = (r_count == COUNT_BITS'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign pop  = (r_count != '0);

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + COUNT_BITS'(push) - COUNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_u[r_wr_ptr] <= i_u_phase;
            r_q_v[r_wr_ptr] <= i_v_phase;
        end
    end

    always_comb begin
        o_job.valid = pop;
        o_job.pu    = TURN_W'(r_q_u[r_rd_ptr]) << (TURN_W - PHASE_BITS);
        o_job.pv    = TURN_W'(r_q_v[r_rd_ptr]) << (TURN_W - PHASE_BITS);
    end

endmodule

// ===== hdl/stpe_cordic.sv =====
// ----------------------------------------------------------------------------
// stpe_cordic
// pipelined cordic rotator, one step per stage, gives cos and sin in q30
// ----------------------------------------------------------------------------
module stpe_cordic (
    input  logic                                i_clk,
    input  logic [stpe_pkg::TURN_W-1:0]         i_phase,
    output logic signed [stpe_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [stpe_pkg::TRIG_W-1:0]  o_sin
);
    import stpe_pkg::*;

    logic signed [CORE_W-1:0]  r_x    [CORDIC_STEPS+1];
    logic signed [CORE_W-1:0]  r_y    [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0] r_z    [CORDIC_STEPS+1];
    logic [1:0]                r_quad [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0]  r_cos;
    logic signed [TRIG_W-1:0]  r_sin;

    always_ff @(posedge i_clk) begin
        r_x[0]    <= CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= $signed({3'b000, i_phase[TURN_W-3:0]});
        r_quad[0] <= i_phase[TURN_W-1:TURN_W-2];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CORE_W-1:0]  dx;
        logic signed [CORE_W-1:0]  dy;
        logic signed [ANGLE_W-1:0] ang;
        assign dx  = r_y[i] >>> i;
        assign dy  = r_x[i] >>> i;
        assign ang = $signed({3'b000, ATAN_TURNS[i]});
        always_ff @(posedge i_clk) begin
            if (!r_z[i][ANGLE_W-1]) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - ang;
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + ang;
            end
            r_quad[i+1] <= r_quad[i];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_quad[CORDIC_STEPS])
            2'd0: begin
                r_cos <= TRIG_W'(r_x[CORDIC_STEPS]);
                r_sin <= TRIG_W'(r_y[CORDIC_STEPS]);
            end
            2'd1: begin
                r_cos <= TRIG_W'(-r_y[CORDIC_STEPS]);
                r_sin <= TRIG_W'(r_x[CORDIC_STEPS]);
            end
            2'd2: begin
                r_cos <= TRIG_W'(-r_x[CORDIC_STEPS]);
                r_sin <= TRIG_W'(-r_y[CORDIC_STEPS]);
            end
            default: begin
                r_cos <= TRIG_W'(r_y[CORDIC_STEPS]);
                r_sin <= TRIG_W'(-r_x[CORDIC_STEPS]);
            end
        endcase
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== hdl/stpe_isqrt.sv =====
// ----------------------------------------------------------------------------
// stpe_isqrt
// pipelined bitwise integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module stpe_isqrt (
    input  logic                          i_clk,
    input  logic [stpe_pkg::WIDE_W-1:0]   i_n,
    output logic [stpe_pkg::ROOT_W-1:0]   o_root
);
    import stpe_pkg::*;

    logic [WIDE_W-1:0] r_n   [ROOT_STEPS];
    logic [WIDE_W-1:0] r_res [ROOT_STEPS];

    for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
        localparam logic [WIDE_W-1:0] BIT = WIDE_W'(1) << (62 - 2 * i);
        logic [WIDE_W-1:0] n_in;
        logic [WIDE_W-1:0] res_in;
        logic [WIDE_W-1:0] trial;
        if (i == 0) begin : g_first
            assign n_in   = i_n;
            assign res_in = '0;
        end else begin : g_next
            assign n_in   = r_n[i-1];
            assign res_in = r_res[i-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge i_clk) begin
            if (n_in >= trial) begin
                r_n[i]   <= n_in - trial;
                r_res[i] <= (res_in >> 1) + BIT;
            end else begin
                r_n[i]   <= n_in;
                r_res[i] <= res_in >> 1;
            end
        end
    end

    assign o_root = r_res[ROOT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== hdl/stpe_back.sv =====
// ----------------------------------------------------------------------------
// stpe_back
// evaluation pipeline: four cordic lanes, products, two square roots,
// rounding and saturation of the three coordinates
// ----------------------------------------------------------------------------
module stpe_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  stpe_pkg::t_job                        i_job,
    output logic                                  o_valid,
    output logic signed [stpe_pkg::COORD_W-1:0]   o_x_pos,
    output logic signed [stpe_pkg::COORD_W-1:0]   o_y_pos,
    output logic signed [stpe_pkg::COORD_W-1:0]   o_z_pos
);
    import stpe_pkg::*;

    logic signed [TRIG_W-1:0] cu, su, cv, sv, cu3, su3, cv3, sv3;
    logic [TURN_W-1:0]        pu3, pv3;

    logic signed [CORE_W-1:0] au, au3;
    logic signed [65:0]       xm, ym;
    logic signed [WIDE_W-1:0] r_xp, r_yp;
    logic signed [WIDE_W-1:0] r_ssu, r_ccu, r_ssv, r_ccv;

    logic signed [WIDE_W-1:0] fu, fv;
    logic [WIDE_W-1:0]        r_magu, r_magv;
    logic                     r_negu, r_negv;
    logic [COORD_W-1:0]       r_xf, r_yf;

    logic [ROOT_W-1:0]        rootu, rootv;
    logic                     r_sgnu [SIGN_DELAY];
    logic                     r_sgnv [SIGN_DELAY];
    logic [COORD_W-1:0]       r_xd   [XY_DELAY];
    logic [COORD_W-1:0]       r_yd   [XY_DELAY];

    logic signed [ROOT_W:0]   sru, srv;
    logic signed [CORE_W-1:0] gu;
    logic signed [66:0]       zm;
    logic signed [WIDE_W-1:0] r_zp;

    logic [COORD_W-1:0]       r_x_out, r_y_out, r_z_out;
    logic [OUT_LAT-1:0]       r_vld;

    assign pu3 = i_job.pu + THIRD_TURN;
    assign pv3 = i_job.pv + THIRD_TURN;

    stpe_cordic u_cordic_u  (.i_clk(i_clk), .i_phase(i_job.pu), .o_cos(cu),  .o_sin(su));
    stpe_cordic u_cordic_v  (.i_clk(i_clk), .i_phase(i_job.pv), .o_cos(cv),  .o_sin(sv));
    stpe_cordic u_cordic_u3 (.i_clk(i_clk), .i_phase(pu3),      .o_cos(cu3), .o_sin(su3));
    stpe_cordic u_cordic_v3 (.i_clk(i_clk), .i_phase(pv3),      .o_cos(cv3), .o_sin(sv3));

    // products
    assign au  = TWO_Q30 + CORE_W'(cu);
    assign au3 = TWO_Q30 + CORE_W'(cu3);
    assign xm  = au * cv;
    assign ym  = au3 * cv3;

    always_ff @(posedge i_clk) begin
        r_xp  <= xm[WIDE_W-1:0];
        r_yp  <= ym[WIDE_W-1:0];
        r_ssu <= su * su;
        r_ccu <= cu3 * cu3;
        r_ssv <= sv * sv;
        r_ccv <= cv3 * cv3;
    end

    // f and its magnitude, x and y rounded
    assign fu = r_ssu - r_ccu;
    assign fv = r_ssv - r_ccv;

    always_ff @(posedge i_clk) begin
        r_negu <= fu[WIDE_W-1];
        r_negv <= fv[WIDE_W-1];
        r_magu <= fu[WIDE_W-1] ? WIDE_W'(-fu) : WIDE_W'(fu);
        r_magv <= fv[WIDE_W-1] ? WIDE_W'(-fv) : WIDE_W'(fv);
        r_xf   <= finish_q60(r_xp);
        r_yf   <= finish_q60(r_yp);
    end

    stpe_isqrt u_isqrt_u (.i_clk(i_clk), .i_n(r_magu), .o_root(rootu));
    stpe_isqrt u_isqrt_v (.i_clk(i_clk), .i_n(r_magv), .o_root(rootv));

    always_ff @(posedge i_clk) begin
        r_sgnu[0] <= r_negu;
        r_sgnv[0] <= r_negv;
        r_xd[0]   <= r_xf;
        r_yd[0]   <= r_yf;
        for (int k = 1; k < SIGN_DELAY; k++) begin
            r_sgnu[k] <= r_sgnu[k-1];
            r_sgnv[k] <= r_sgnv[k-1];
        end
        for (int k = 1; k < XY_DELAY; k++) begin
            r_xd[k] <= r_xd[k-1];
            r_yd[k] <= r_yd[k-1];
        end
    end

    // z product
    assign sru = r_sgnu[SIGN_DELAY-1] ? -$signed({1'b0, rootu}) : $signed({1'b0, rootu});
    assign srv = r_sgnv[SIGN_DELAY-1] ? -$signed({1'b0, rootv}) : $signed({1'b0, rootv});
    assign gu  = TWO_Q30 + CORE_W'(sru);
    assign zm  = gu * srv;

    always_ff @(posedge i_clk) begin
        r_zp    <= zm[WIDE_W-1:0];
        r_x_out <= r_xd[XY_DELAY-1];
        r_y_out <= r_yd[XY_DELAY-1];
        r_z_out <= finish_q60(r_zp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[OUT_LAT-2:0], i_job.valid};
        end
    end

    assign o_valid = r_vld[OUT_LAT-1];
    assign o_x_pos = r_x_out;
    assign o_y_pos = r_y_out;
    assign o_z_pos = r_z_out;

endmodule

// ===== hdl/stpe_checker.sv =====
// ----------------------------------------------------------------------------
// stpe_checker
// port level checks of start to strobe timing and of quiet outputs after reset
// ----------------------------------------------------------------------------
module stpe_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic [stpe_pkg::PHASE_W-1:0]          i_u_phase,
    input  logic [stpe_pkg::PHASE_W-1:0]          i_v_phase,
    input  logic                                  busy,
    input  logic                                  o_valid,
    input  logic signed [stpe_pkg::COORD_W-1:0]   o_x_pos,
    input  logic signed [stpe_pkg::COORD_W-1:0]   o_y_pos,
    input  logic signed [stpe_pkg::COORD_W-1:0]   o_z_pos
);
    import stpe_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("busy or strobe right after reset");

    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(OUT_LAT + 1) o_valid)
        else $error("accepted transaction gave no result");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, OUT_LAT + 1))
        else $error("result without accepted transaction");

endmodule

bind saddle_torus_point_eval stpe_checker u_stpe_checker (.*);
